/* rtl/jpeg_coefficient_run_expander_core_assert.svh */
// Assertion macros for the coefficient run expander.
`ifndef JPEG_COEFFICIENT_RUN_EXPANDER_CORE_ASSERT_SVH
`define JPEG_COEFFICIENT_RUN_EXPANDER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Condition that holds on every clock edge out of reset.
`define JCRE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("jcre: invariant violated");
// Condition that holds in the cycle after a trigger.
`define JCRE_ASSERT_NEXT(lbl, trig, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("jcre: sequence violated");
`else
`define JCRE_ASSERT_ALWAYS(lbl, expr)
`define JCRE_ASSERT_NEXT(lbl, trig, expr)
`endif

`endif

/* rtl/jcre_pkg.sv */
// Shared types, constants and the EXTEND function of the coefficient run expander.
package jcre_pkg;

  localparam logic [7:0] RunMask  = 8'hF0;
  localparam logic [7:0] SizeMask = 8'h0F;
  localparam int         RunShift = 4;
  localparam logic [6:0] LastPos  = 7'd63;
  localparam int         BlockLen = 64;
  localparam int         RowLen   = 8;

  // natural index (row * 8 + col) of each zigzag position
  localparam logic [5:0] ZzNatural [BlockLen] = '{
     0,  1,  8, 16,  9,  2,  3, 10,
    17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34,
    27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36,
    29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46,
    53, 60, 61, 54, 47, 55, 62, 63
  };

  typedef struct packed {
    logic [7:0]  symbol;
    logic [14:0] extra_bits;
  } sym_t;

  typedef struct packed {
    logic [5:0]         zz_position;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] coefficient;
    logic               is_eob;
    logic               block_end;
    logic               overrun;
  } coef_t;

  // JPEG EXTEND of the low size bits
  function automatic logic signed [15:0] extend(input logic [14:0] bits,
                                                input logic [3:0]  size);
    logic [15:0] mask;
    logic [15:0] b;
    mask = (16'd1 << size) - 16'd1;
    b    = {1'b0, bits} & mask;
    if (size == 4'd0) begin
      return 16'sd0;
    end
    if (b[4'(size - 4'd1)]) begin
      return signed'(b);
    end
    return signed'(b - mask);
  endfunction

endpackage

/* rtl/jcre_if.sv */
// Request channels: symbols in, coefficient placements out.
interface jcre_sym_if;
  logic        valid;
  logic        ready;
  logic [7:0]  symbol;
  logic [14:0] extra_bits;

  modport source (output valid, output symbol, output extra_bits, input ready);
  modport sink (input valid, input symbol, input extra_bits, output ready);
endinterface

interface jcre_coef_if;
  logic               valid;
  logic               ready;
  logic [5:0]         zz_position;
  logic [2:0]         row;
  logic [2:0]         col;
  logic signed [15:0] coefficient;
  logic               is_eob;
  logic               block_end;
  logic               overrun;

  modport source (output valid, output zz_position, output row, output col,
                  output coefficient, output is_eob, output block_end,
                  output overrun, input ready);
  modport sink (input valid, input zz_position, input row, input col,
                input coefficient, input is_eob, input block_end,
                input overrun, output ready);
endinterface

/* rtl/jpeg_coefficient_run_expander_core.sv */
// Top level of the JPEG coefficient run expander.
//
//   channel   dir  payload                                      request
//   symbols   in   symbol, extra_bits                            one symbol
//   coefs     out  zz_position, row, col, coefficient, flags     one placement
//
// One placement per symbol; a new symbol is taken every cycle while coefs is not stalled.
// A symbol passes through two registers: input register, then result register.
// The add, compare and zigzag lookup between them set the cycle.
// Reset clears the valid flags and starts a block with its DC symbol.
// A stalled result holds; the input register takes one more symbol if empty, then stalls symbols.
module jpeg_coefficient_run_expander_core
  import jcre_pkg::*;
(
  input logic         clk,
  input logic         rst,
  jcre_sym_if.sink    symbols,
  jcre_coef_if.source coefs
);

  logic  s1_valid;
  sym_t  s1_item;
  logic  out_valid;
  coef_t out_res;
  coef_t step_res;
  logic  advance;

  assign advance       = s1_valid && (!out_valid || coefs.ready);
  assign symbols.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (symbols.ready) begin
      s1_valid <= symbols.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (symbols.valid && symbols.ready) begin
      s1_item.symbol     <= symbols.symbol;
      s1_item.extra_bits <= symbols.extra_bits;
    end
  end

  jcre_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .result (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || coefs.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign coefs.valid       = out_valid;
  assign coefs.zz_position = out_res.zz_position;
  assign coefs.row         = out_res.row;
  assign coefs.col         = out_res.col;
  assign coefs.coefficient = out_res.coefficient;
  assign coefs.is_eob      = out_res.is_eob;
  assign coefs.block_end   = out_res.block_end;
  assign coefs.overrun     = out_res.overrun;

endmodule

/* rtl/jcre_step.sv */
// Block position state and the per-symbol expansion logic.
module jcre_step
  import jcre_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  sym_t  item,
  output coef_t result
);

  `include "jpeg_coefficient_run_expander_core_assert.svh"

  logic [5:0] position;
  logic [5:0] position_next;
  logic       awaiting_dc;
  logic       awaiting_dc_next;

  logic [3:0] run;
  logic [3:0] size;
  logic [6:0] target;
  logic [5:0] nat;

  assign run    = 4'((item.symbol & RunMask) >> RunShift);
  assign size   = 4'(item.symbol & SizeMask);
  assign target = {1'b0, position} + {3'b000, run} + 7'd1;

  always_comb begin
    result           = '0;
    position_next    = position;
    awaiting_dc_next = awaiting_dc;
    if (awaiting_dc) begin
      awaiting_dc_next = 1'b0;
      position_next    = '0;
      if (item.symbol > 8'(SizeMask)) begin
        result.overrun = 1'b1;
      end else begin
        result.coefficient = extend(item.extra_bits, size);
      end
    end else if (item.symbol == 8'd0) begin
      result.is_eob    = 1'b1;
      result.block_end = 1'b1;
      awaiting_dc_next = 1'b1;
      position_next    = '0;
    end else if (target > LastPos) begin
      result.overrun   = 1'b1;
      result.block_end = 1'b1;
      awaiting_dc_next = 1'b1;
      position_next    = '0;
    end else begin
      result.zz_position = target[5:0];
      result.coefficient = extend(item.extra_bits, size);
      if (target == LastPos) begin
        result.block_end = 1'b1;
        awaiting_dc_next = 1'b1;
        position_next    = '0;
      end else begin
        position_next = target[5:0];
      end
    end
    nat        = ZzNatural[result.zz_position];
    result.row = 3'(nat / RowLen);
    result.col = 3'(nat % RowLen);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      awaiting_dc <= 1'b1;
    end else if (fire) begin
      position    <= position_next;
      awaiting_dc <= awaiting_dc_next;
    end
  end

  `JCRE_ASSERT_ALWAYS(a_dc_at_origin, !awaiting_dc || position == 6'd0)
  `JCRE_ASSERT_ALWAYS(a_eob_ends_block, !result.is_eob || result.block_end)
  `JCRE_ASSERT_NEXT(a_dc_consumed, fire && awaiting_dc, !awaiting_dc)
  `JCRE_ASSERT_NEXT(a_end_rearms_dc, fire && result.block_end, awaiting_dc)

endmodule
